// ===== rtl/core/wsrmm_pkg.sv =====
package wsrmm_pkg;

    // Default sizes for the top-level parameters
    localparam int DEPTH_DEFAULT       = 1024;
    localparam int SAMPLE_BITS_DEFAULT = 32;

    // Fixed field widths
    localparam int TS_W      = 64;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd2;

    // Configuration reset values
    localparam logic            ENABLE_RESET       = 1'b0;
    localparam logic [CFG_W-1:0] WINDOW_RESET       = 32'd10000000;
    localparam logic [CFG_W-1:0] MIN_INTERVAL_RESET = 32'd0;

    typedef enum logic [1:0] {
        OP_PUSH      = 2'd0,
        OP_RECOMPUTE = 2'd1,
        OP_READ      = 2'd2,
        OP_CLEAR     = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH_CHECK,
        ST_PUSH_EVICT,
        ST_PUSH_WRITE,
        ST_REC_START,
        ST_REC_WALK,
        ST_READ_ADDR,
        ST_READ_DATA,
        ST_CLEAR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic             enable;
        logic [CFG_W-1:0] window_us;
        logic [CFG_W-1:0] min_interval_us;
    } cfg_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } head_t;

endpackage

// ===== rtl/core/wsrmm_ram.sv =====
module wsrmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/wsrmm_front.sv =====
module wsrmm_front #(
    parameter int DEPTH       = wsrmm_pkg::DEPTH_DEFAULT,
    parameter int SAMPLE_BITS = wsrmm_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic [wsrmm_pkg::TS_W-1:0]    timestamp,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [$clog2(DEPTH)-1:0]      read_index,
    output wsrmm_pkg::head_t              head,
    output logic [wsrmm_pkg::TS_W-1:0]    head_ts,
    output logic signed [SAMPLE_BITS-1:0] head_sample,
    output logic [$clog2(DEPTH)-1:0]      head_idx,
    input  logic                          pop
);

    localparam int AW = $clog2(DEPTH);
    localparam int QD = wsrmm_pkg::QUEUE_DEPTH;
    localparam logic [wsrmm_pkg::QUEUE_PTR_W-1:0] Q_LAST =
        wsrmm_pkg::QUEUE_PTR_W'(QD - 1);
    localparam logic [wsrmm_pkg::QUEUE_CNT_W-1:0] Q_FULL =
        wsrmm_pkg::QUEUE_CNT_W'(QD);

    wsrmm_pkg::op_t                      q_op_reg     [QD];
    logic [wsrmm_pkg::TS_W-1:0]          q_ts_reg     [QD];
    logic signed [SAMPLE_BITS-1:0]       q_sample_reg [QD];
    logic [AW-1:0]                       q_idx_reg    [QD];
    logic [wsrmm_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [wsrmm_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [wsrmm_pkg::QUEUE_CNT_W-1:0]   fill_reg, fill_next;
    logic                                push;
    wsrmm_pkg::op_t                      op_class;

    // Classify the incoming word by its operation code
    assign op_class = wsrmm_pkg::op_t'(op);

    assign in_stall = (fill_reg == Q_FULL);
    assign push     = in_valid && !in_stall;

    // Advance the queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the accepted word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_op_reg[wr_ptr_reg]     <= op_class;
            q_ts_reg[wr_ptr_reg]     <= timestamp;
            q_sample_reg[wr_ptr_reg] <= sample_in;
            q_idx_reg[wr_ptr_reg]    <= read_index;
        end
    end

    // Present the queue head to the back end
    assign head.valid  = (fill_reg != '0);
    assign head.op     = q_op_reg[rd_ptr_reg];
    assign head_ts     = q_ts_reg[rd_ptr_reg];
    assign head_sample = q_sample_reg[rd_ptr_reg];
    assign head_idx    = q_idx_reg[rd_ptr_reg];

endmodule

// ===== rtl/core/wsrmm_back.sv =====
module wsrmm_back #(
    parameter int DEPTH       = wsrmm_pkg::DEPTH_DEFAULT,
    parameter int SAMPLE_BITS = wsrmm_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wsrmm_pkg::cfg_t                cfg,
    input  wsrmm_pkg::head_t               head,
    input  logic [wsrmm_pkg::TS_W-1:0]     head_ts,
    input  logic signed [SAMPLE_BITS-1:0]  head_sample,
    input  logic [$clog2(DEPTH)-1:0]       head_idx,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           accepted,
    output logic signed [SAMPLE_BITS-1:0]  min_value,
    output logic signed [SAMPLE_BITS-1:0]  max_value,
    output logic                           minmax_stale,
    output logic [$clog2(DEPTH+1)-1:0]     sample_count,
    output logic                           read_valid,
    output logic [wsrmm_pkg::TS_W-1:0]     read_timestamp,
    output logic signed [SAMPLE_BITS-1:0]  read_sample
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = wsrmm_pkg::TS_W;
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_S  = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    wsrmm_pkg::state_t             state_reg, state_next;
    logic [TW-1:0]                 cur_ts_reg, cur_ts_next;
    logic signed [SAMPLE_BITS-1:0] cur_sample_reg, cur_sample_next;
    logic [AW-1:0]                 cur_idx_reg, cur_idx_next;
    logic [AW-1:0]                 oldest_reg, oldest_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [TW-1:0]                 last_reg, last_next;
    logic signed [SAMPLE_BITS-1:0] low_reg, low_next;
    logic signed [SAMPLE_BITS-1:0] high_reg, high_next;
    logic                          stale_reg, stale_next;
    logic [AW-1:0]                 wr_addr_reg, wr_addr_next;
    logic [AW-1:0]                 walk_ptr_reg, walk_ptr_next;
    logic [CW-1:0]                 walk_left_reg, walk_left_next;
    logic                          walk_first_reg, walk_first_next;
    logic                          acc_reg, acc_next;
    logic                          rvalid_reg, rvalid_next;
    logic [TW-1:0]                 rts_reg, rts_next;
    logic signed [SAMPLE_BITS-1:0] rval_reg, rval_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_acc_reg;
    logic signed [SAMPLE_BITS-1:0] out_min_reg;
    logic signed [SAMPLE_BITS-1:0] out_max_reg;
    logic                          out_stale_reg;
    logic [CW-1:0]                 out_count_reg;
    logic                          out_rvalid_reg;
    logic [TW-1:0]                 out_rts_reg;
    logic signed [SAMPLE_BITS-1:0] out_rval_reg;

    logic                          out_free;
    logic                          out_load;
    logic                          dispatch;
    logic                          ram_we;
    logic [AW-1:0]                 rd_addr;
    logic [TW-1:0]                 rd_time;
    logic [SAMPLE_BITS-1:0]        rd_value_raw;
    logic signed [SAMPLE_BITS-1:0] rd_value;
    logic [TW-1:0]                 gap;
    logic [TW-1:0]                 age;
    logic                          reject;
    logic                          expired;
    logic                          hits_mark;

    // Next ring position, wrapping at the store depth
    function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] p);
        pos_inc = (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    // Ring position of the entry at a given age
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW + 1)'(off);
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        slot_of = sum[AW-1:0];
    endfunction

    // Sample store: timestamps and values side by side
    wsrmm_ram #(
        .WIDTH (TW),
        .DEPTH (DEPTH)
    ) u_time_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr_reg),
        .wdata (cur_ts_reg),
        .raddr (rd_addr),
        .rdata (rd_time)
    );

    wsrmm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr_reg),
        .wdata (cur_sample_reg),
        .raddr (rd_addr),
        .rdata (rd_value_raw)
    );

    assign rd_value = rd_value_raw;

    // Push checks against the last stored timestamp and the oldest entry
    assign gap       = cur_ts_reg - last_reg;
    assign age       = cur_ts_reg - rd_time;
    assign reject    = !cfg.enable ||
                       ((count_reg != '0) &&
                        ((cur_ts_reg <= last_reg) ||
                         (gap < TW'(cfg.min_interval_us))));
    assign expired   = (age > TW'(cfg.window_us));
    assign hits_mark = (rd_value == low_reg) || (rd_value == high_reg);

    assign out_free = !out_valid_reg || !out_stall;

    // Sequence the current operation
    always_comb
    begin
        state_next      = state_reg;
        cur_ts_next     = cur_ts_reg;
        cur_sample_next = cur_sample_reg;
        cur_idx_next    = cur_idx_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        stale_next      = stale_reg;
        wr_addr_next    = wr_addr_reg;
        walk_ptr_next   = walk_ptr_reg;
        walk_left_next  = walk_left_reg;
        walk_first_next = walk_first_reg;
        acc_next        = acc_reg;
        rvalid_next     = rvalid_reg;
        rts_next        = rts_reg;
        rval_next       = rval_reg;
        rd_addr         = oldest_reg;
        ram_we          = 1'b0;
        out_load        = 1'b0;
        dispatch        = 1'b0;
        pop             = 1'b0;

        case (state_reg)
            wsrmm_pkg::ST_IDLE:
            begin
                dispatch = head.valid;
            end

            // Drop a rejected push, start an empty store, or fetch the oldest
            wsrmm_pkg::ST_PUSH_CHECK:
            begin
                if (reject)
                begin
                    state_next = wsrmm_pkg::ST_RESP;
                end
                else if (count_reg == '0)
                begin
                    wr_addr_next = oldest_reg;
                    count_next   = CW'(1);
                    state_next   = wsrmm_pkg::ST_PUSH_WRITE;
                end
                else
                begin
                    rd_addr    = oldest_reg;
                    state_next = wsrmm_pkg::ST_PUSH_EVICT;
                end
            end

            // Evict one expired entry per cycle, then pick the write slot
            wsrmm_pkg::ST_PUSH_EVICT:
            begin
                if ((count_reg != '0) && expired)
                begin
                    if (hits_mark)
                    begin
                        stale_next = 1'b1;
                    end
                    oldest_next = pos_inc(oldest_reg);
                    count_next  = count_reg - 1'b1;
                    rd_addr     = pos_inc(oldest_reg);
                end
                else if (count_reg != FULL_CNT)
                begin
                    wr_addr_next = slot_of(oldest_reg, count_reg);
                    count_next   = count_reg + 1'b1;
                    state_next   = wsrmm_pkg::ST_PUSH_WRITE;
                end
                else
                begin
                    if (hits_mark)
                    begin
                        stale_next = 1'b1;
                    end
                    wr_addr_next = oldest_reg;
                    oldest_next  = pos_inc(oldest_reg);
                    state_next   = wsrmm_pkg::ST_PUSH_WRITE;
                end
            end

            // Store the sample and widen the tracked range, or restart it at a lone entry
            wsrmm_pkg::ST_PUSH_WRITE:
            begin
                ram_we    = 1'b1;
                last_next = cur_ts_reg;
                acc_next  = 1'b1;
                if (count_reg == CW'(1))
                begin
                    low_next   = cur_sample_reg;
                    high_next  = cur_sample_reg;
                    stale_next = 1'b0;
                end
                else
                begin
                    if (cur_sample_reg < low_reg)
                    begin
                        low_next = cur_sample_reg;
                    end
                    if (high_reg < cur_sample_reg)
                    begin
                        high_next = cur_sample_reg;
                    end
                end
                state_next = wsrmm_pkg::ST_RESP;
            end

            wsrmm_pkg::ST_REC_START:
            begin
                stale_next = 1'b0;
                if (count_reg == '0)
                begin
                    low_next   = '0;
                    high_next  = '0;
                    state_next = wsrmm_pkg::ST_RESP;
                end
                else
                begin
                    rd_addr         = oldest_reg;
                    walk_ptr_next   = oldest_reg;
                    walk_left_next  = count_reg;
                    walk_first_next = 1'b1;
                    state_next      = wsrmm_pkg::ST_REC_WALK;
                end
            end

            // Fold one held entry per cycle into the range
            wsrmm_pkg::ST_REC_WALK:
            begin
                walk_first_next = 1'b0;
                if (walk_first_reg || (rd_value < low_reg))
                begin
                    low_next = rd_value;
                end
                if (walk_first_reg || (high_reg < rd_value))
                begin
                    high_next = rd_value;
                end
                rd_addr        = pos_inc(walk_ptr_reg);
                walk_ptr_next  = pos_inc(walk_ptr_reg);
                walk_left_next = walk_left_reg - 1'b1;
                if (walk_left_reg == CW'(1))
                begin
                    state_next = wsrmm_pkg::ST_RESP;
                end
            end

            wsrmm_pkg::ST_READ_ADDR:
            begin
                if (CW'(cur_idx_reg) < count_reg)
                begin
                    rd_addr    = slot_of(oldest_reg, CW'(cur_idx_reg));
                    state_next = wsrmm_pkg::ST_READ_DATA;
                end
                else
                begin
                    state_next = wsrmm_pkg::ST_RESP;
                end
            end

            wsrmm_pkg::ST_READ_DATA:
            begin
                rvalid_next = 1'b1;
                rts_next    = rd_time;
                rval_next   = rd_value;
                state_next  = wsrmm_pkg::ST_RESP;
            end

            wsrmm_pkg::ST_CLEAR:
            begin
                oldest_next = '0;
                count_next  = '0;
                last_next   = '0;
                low_next    = '0;
                high_next   = '0;
                stale_next  = 1'b0;
                state_next  = wsrmm_pkg::ST_RESP;
            end

            // Hand the word to the output register, then take the next command
            wsrmm_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    dispatch = head.valid;
                    if (!head.valid)
                    begin
                        state_next = wsrmm_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = wsrmm_pkg::ST_IDLE;
            end
        endcase

        // Take the queue head and branch on its class
        if (dispatch)
        begin
            pop             = 1'b1;
            cur_ts_next     = head_ts;
            cur_sample_next = head_sample;
            cur_idx_next    = head_idx;
            acc_next        = 1'b0;
            rvalid_next     = 1'b0;
            rts_next        = '0;
            rval_next       = '0;
            case (head.op)
                wsrmm_pkg::OP_PUSH:      state_next = wsrmm_pkg::ST_PUSH_CHECK;
                wsrmm_pkg::OP_RECOMPUTE: state_next = wsrmm_pkg::ST_REC_START;
                wsrmm_pkg::OP_READ:      state_next = wsrmm_pkg::ST_READ_ADDR;
                wsrmm_pkg::OP_CLEAR:     state_next = wsrmm_pkg::ST_CLEAR;
                default:                 state_next = wsrmm_pkg::ST_IDLE;
            endcase
        end

        // Hold the output word until it is taken
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and store state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wsrmm_pkg::ST_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            last_reg      <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            stale_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            stale_reg     <= stale_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command, walk and result payload
    always_ff @(posedge clk)
    begin
        cur_ts_reg     <= cur_ts_next;
        cur_sample_reg <= cur_sample_next;
        cur_idx_reg    <= cur_idx_next;
        wr_addr_reg    <= wr_addr_next;
        walk_ptr_reg   <= walk_ptr_next;
        walk_left_reg  <= walk_left_next;
        walk_first_reg <= walk_first_next;
        acc_reg        <= acc_next;
        rvalid_reg     <= rvalid_next;
        rts_reg        <= rts_next;
        rval_reg       <= rval_next;
        if (out_load)
        begin
            out_acc_reg    <= acc_reg;
            out_min_reg    <= low_reg;
            out_max_reg    <= high_reg;
            out_stale_reg  <= stale_reg;
            out_count_reg  <= count_reg;
            out_rvalid_reg <= rvalid_reg;
            out_rts_reg    <= rts_reg;
            out_rval_reg   <= rval_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = out_acc_reg;
    assign min_value      = out_min_reg;
    assign max_value      = out_max_reg;
    assign minmax_stale   = out_stale_reg;
    assign sample_count   = out_count_reg;
    assign read_valid     = out_rvalid_reg;
    assign read_timestamp = out_rts_reg;
    assign read_sample    = out_rval_reg;

    // The store never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("sample count exceeds store depth");

    // Tracked minimum never passes the tracked maximum
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg <= high_reg)
        else $error("tracked minimum above tracked maximum");

    // A stored sample leaves the store non-empty
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wsrmm_pkg::ST_RESP && acc_reg) |-> (count_reg != '0))
        else $error("accepted push left an empty store");

    // A valid read lies within the held entries
    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wsrmm_pkg::ST_RESP && rvalid_reg) |->
        (CW'(cur_idx_reg) < count_reg))
        else $error("read marked valid beyond held count");

    // Only take a command the queue actually holds
    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("command taken from an empty queue");

endmodule

// ===== rtl/core/windowed_sample_ring_minmax_top.sv =====
// Windowed sample ring with running minimum and maximum.
// Input channel (in_valid/in_stall) carries one command word: op selects push,
// recompute, read or clear; timestamp and sample_in feed push, read_index
// feeds read. Every command yields exactly one word on the output channel
// (out_valid/out_stall) with the tracked range, count and read result.
// A two-entry command queue sits in front of the execution sequencer, which
// owns a single-read-port sample memory and an output register.
// Commands run from the queue head through sequencer states: push checks,
// evicts expired entries and then writes (a rejected push skips both), read
// addresses then fetches (an out-of-range read skips the fetch), clear resets
// the store, and recompute walks every held entry. The memory read port sets
// the pace there: one entry is visited per cycle.
// Config writes (cfg_write/cfg_index/cfg_data) belong in idle periods.
// Reset empties the store and the queue and loads register defaults
// (disabled, 10 s window, no minimum interval); memory contents are not
// cleared since only held entries are ever read.
// A stalled output word holds; the sequencer finishes the next command and
// waits, and the queue then fills and raises in_stall.
module windowed_sample_ring_minmax_top #(
    parameter int DEPTH       = wsrmm_pkg::DEPTH_DEFAULT,
    parameter int SAMPLE_BITS = wsrmm_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [wsrmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wsrmm_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           op,
    input  logic [wsrmm_pkg::TS_W-1:0]           timestamp,
    input  logic signed [SAMPLE_BITS-1:0]        sample_in,
    input  logic [$clog2(DEPTH)-1:0]             read_index,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 accepted,
    output logic signed [SAMPLE_BITS-1:0]        min_value,
    output logic signed [SAMPLE_BITS-1:0]        max_value,
    output logic                                 minmax_stale,
    output logic [$clog2(DEPTH+1)-1:0]           sample_count,
    output logic                                 read_valid,
    output logic [wsrmm_pkg::TS_W-1:0]           read_timestamp,
    output logic signed [SAMPLE_BITS-1:0]        read_sample
);

    wsrmm_pkg::cfg_t               cfg_reg, cfg_next;
    wsrmm_pkg::head_t              head;
    logic [wsrmm_pkg::TS_W-1:0]    head_ts;
    logic signed [SAMPLE_BITS-1:0] head_sample;
    logic [$clog2(DEPTH)-1:0]      head_idx;
    logic                          pop;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                wsrmm_pkg::CFG_ENABLE:       cfg_next.enable          = cfg_data[0];
                wsrmm_pkg::CFG_WINDOW:       cfg_next.window_us       = cfg_data;
                wsrmm_pkg::CFG_MIN_INTERVAL: cfg_next.min_interval_us = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable          <= wsrmm_pkg::ENABLE_RESET;
            cfg_reg.window_us       <= wsrmm_pkg::WINDOW_RESET;
            cfg_reg.min_interval_us <= wsrmm_pkg::MIN_INTERVAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wsrmm_front #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .timestamp   (timestamp),
        .sample_in   (sample_in),
        .read_index  (read_index),
        .head        (head),
        .head_ts     (head_ts),
        .head_sample (head_sample),
        .head_idx    (head_idx),
        .pop         (pop)
    );

    wsrmm_back #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .head           (head),
        .head_ts        (head_ts),
        .head_sample    (head_sample),
        .head_idx       (head_idx),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .min_value      (min_value),
        .max_value      (max_value),
        .minmax_stale   (minmax_stale),
        .sample_count   (sample_count),
        .read_valid     (read_valid),
        .read_timestamp (read_timestamp),
        .read_sample    (read_sample)
    );

endmodule

// ===== dv/windowed_sample_ring_minmax_top_test.sv =====
module windowed_sample_ring_minmax_top_test;

    localparam int TS_W       = wsrmm_pkg::TS_W;
    localparam int CFG_W      = wsrmm_pkg::CFG_W;
    localparam int CFG_IDX_W  = wsrmm_pkg::CFG_IDX_W;
    localparam int RING_DEPTH = wsrmm_pkg::DEPTH_DEFAULT;
    localparam int VAL_W      = wsrmm_pkg::SAMPLE_BITS_DEFAULT;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [TS_W-1:0]         TS_MAX  = '1;
    localparam logic [CFG_W-1:0]        CFG_ALL_ONES = '1;

    // One expected result word
    typedef struct packed {
        logic             accepted;
        logic [VAL_W-1:0] low;
        logic [VAL_W-1:0] high;
        logic             stale;
        logic [CNT_W-1:0] count;
        logic             hit;
        logic [TS_W-1:0]  stamp;
        logic [VAL_W-1:0] value;
    } ring_status_t;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index  = '0;
    logic [CFG_W-1:0]        cfg_data   = '0;
    logic                    in_valid   = 1'b0;
    logic                    in_stall;
    logic [1:0]              op         = '0;
    logic [TS_W-1:0]         timestamp  = '0;
    logic signed [VAL_W-1:0] sample_in  = '0;
    logic [IDX_W-1:0]        read_index = '0;
    logic                    out_valid;
    logic                    out_stall  = 1'b0;
    logic                    accepted;
    logic signed [VAL_W-1:0] min_value;
    logic signed [VAL_W-1:0] max_value;
    logic                    minmax_stale;
    logic [CNT_W-1:0]        sample_count;
    logic                    read_valid;
    logic [TS_W-1:0]         read_timestamp;
    logic signed [VAL_W-1:0] read_sample;

    // Shadow copy of the ring and its registers
    logic [TS_W-1:0]         stamp_mem [RING_DEPTH];
    logic signed [VAL_W-1:0] value_mem [RING_DEPTH];
    logic [IDX_W-1:0]        head_pos     = '0;
    logic [CNT_W-1:0]        fill         = '0;
    logic [TS_W-1:0]         newest_stamp = '0;
    logic signed [VAL_W-1:0] low_val      = '0;
    logic signed [VAL_W-1:0] high_val     = '0;
    logic                    range_stale  = 1'b0;
    logic                    cfg_on       = wsrmm_pkg::ENABLE_RESET;
    logic [CFG_W-1:0]        cfg_window   = wsrmm_pkg::WINDOW_RESET;
    logic [CFG_W-1:0]        cfg_gap      = wsrmm_pkg::MIN_INTERVAL_RESET;

    ring_status_t status_due [$];

    int idle_pct = 36;
    int stall_pct = 36;
    int mismatch_count = 0;
    int n_checked = 0;
    int n_taken = 0;
    int n_refused = 0;
    int n_hits = 0;
    int n_walks = 0;
    int n_wipes = 0;
    int peak_fill = 0;

    windowed_sample_ring_minmax_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .timestamp      (timestamp),
        .sample_in      (sample_in),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .min_value      (min_value),
        .max_value      (max_value),
        .minmax_stale   (minmax_stale),
        .sample_count   (sample_count),
        .read_valid     (read_valid),
        .read_timestamp (read_timestamp),
        .read_sample    (read_sample)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Mark range as possibly outdated when a dropped entry held an extreme
    task automatic note_evicted(input logic signed [VAL_W-1:0] gone);
        if (gone == low_val || gone == high_val)
            range_stale = 1'b1;
    endtask

    // Apply one accepted command to the shadow ring and queue its status word
    task automatic advance_ring(input wsrmm_pkg::op_t kind, input logic [TS_W-1:0] stamp,
                                input logic signed [VAL_W-1:0] value,
                                input logic [IDX_W-1:0] index);
        ring_status_t     status;
        logic             ok;
        logic [IDX_W-1:0] slot_pos;
        logic [TS_W-1:0]  win64;
        logic [TS_W-1:0]  gap64;
        int               k;
        status = '0;
        win64 = {{(TS_W-CFG_W){1'b0}}, cfg_window};
        gap64 = {{(TS_W-CFG_W){1'b0}}, cfg_gap};
        case (kind)
            wsrmm_pkg::OP_PUSH:
            begin
                ok = cfg_on;
                // Time checks apply only while entries are held
                if (ok && fill != 0)
                begin
                    if (stamp <= newest_stamp)
                        ok = 1'b0;
                    else if (stamp - newest_stamp < gap64)
                        ok = 1'b0;
                end
                if (ok)
                begin
                    // Drop entries older than the window
                    while (fill != 0 && stamp - stamp_mem[head_pos] > win64)
                    begin
                        note_evicted(value_mem[head_pos]);
                        head_pos = head_pos + 1'b1;
                        fill = fill - 1'b1;
                    end
                    // Append, or overwrite the oldest entry when full
                    if (fill < RING_DEPTH)
                    begin
                        slot_pos = head_pos + fill[IDX_W-1:0];
                        fill = fill + 1'b1;
                    end
                    else
                    begin
                        note_evicted(value_mem[head_pos]);
                        slot_pos = head_pos;
                        head_pos = head_pos + 1'b1;
                    end
                    stamp_mem[slot_pos] = stamp;
                    value_mem[slot_pos] = value;
                    newest_stamp = stamp;
                    if (fill == 1)
                    begin
                        low_val = value;
                        high_val = value;
                        range_stale = 1'b0;
                    end
                    else
                    begin
                        if (value < low_val)
                            low_val = value;
                        if (value > high_val)
                            high_val = value;
                    end
                    n_taken++;
                end
                else
                begin
                    n_refused++;
                end
                status.accepted = ok;
            end
            wsrmm_pkg::OP_RECOMPUTE:
            begin
                // Walk held entries oldest first
                range_stale = 1'b0;
                if (fill == 0)
                begin
                    low_val = '0;
                    high_val = '0;
                end
                else
                begin
                    low_val = value_mem[head_pos];
                    high_val = low_val;
                    for (k = 1; k < fill; k++)
                    begin
                        slot_pos = head_pos + IDX_W'(k);
                        if (value_mem[slot_pos] < low_val)
                            low_val = value_mem[slot_pos];
                        if (value_mem[slot_pos] > high_val)
                            high_val = value_mem[slot_pos];
                    end
                end
                n_walks++;
            end
            wsrmm_pkg::OP_READ:
            begin
                if ({1'b0, index} < fill)
                begin
                    slot_pos = head_pos + index;
                    status.hit = 1'b1;
                    status.stamp = stamp_mem[slot_pos];
                    status.value = value_mem[slot_pos];
                    n_hits++;
                end
            end
            wsrmm_pkg::OP_CLEAR:
            begin
                head_pos = '0;
                fill = '0;
                newest_stamp = '0;
                low_val = '0;
                high_val = '0;
                range_stale = 1'b0;
                n_wipes++;
            end
            default: ;
        endcase
        status.low = low_val;
        status.high = high_val;
        status.stale = range_stale;
        status.count = fill;
        status_due.push_back(status);
        if (fill > peak_fill)
            peak_fill = fill;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin : check_out
        ring_status_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result word with none expected, actual count %0d",
                         $time, sample_count);
            end
            else
            begin
                want = status_due.pop_front();
                n_checked++;
                check_field("accepted", want.accepted, accepted);
                check_field("min_value", want.low, $unsigned(min_value));
                check_field("max_value", want.high, $unsigned(max_value));
                check_field("minmax_stale", want.stale, minmax_stale);
                check_field("sample_count", want.count, sample_count);
                check_field("read_valid", want.hit, read_valid);
                check_field("read_timestamp", want.stamp, read_timestamp);
                check_field("read_sample", want.value, $unsigned(read_sample));
            end
        end
    end

    // Send one command word, idling at random first
    task automatic send_word(input wsrmm_pkg::op_t kind, input logic [TS_W-1:0] stamp,
                             input logic signed [VAL_W-1:0] value,
                             input logic [IDX_W-1:0] index);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= kind;
        timestamp <= stamp;
        sample_in <= value;
        read_index <= index;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_ring(kind, stamp, value, index);
    endtask

    // Hold the input low until every expected word has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (status_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (index)
            wsrmm_pkg::CFG_ENABLE:       cfg_on = data[0];
            wsrmm_pkg::CFG_WINDOW:       cfg_window = data;
            wsrmm_pkg::CFG_MIN_INTERVAL: cfg_gap = data;
            default: ;
        endcase
    endtask

    // Mostly well-formed timestamps, some stale, some at the window edge
    function automatic logic [TS_W-1:0] pick_stamp(input int stride);
        int              roll;
        logic [TS_W-1:0] win;
        logic [TS_W-1:0] gap;
        roll = $urandom_range(99);
        win = {{(TS_W-CFG_W){1'b0}}, cfg_window};
        gap = {{(TS_W-CFG_W){1'b0}}, cfg_gap};
        if (fill == 0 && roll < 40)
            return {$urandom, $urandom} >> 1;
        if (roll < 55)
            return newest_stamp + gap + TS_W'($urandom_range(0, stride));
        if (roll < 65)
            return newest_stamp + gap;
        if (fill != 0 && roll < 75)
            return stamp_mem[head_pos] + win + TS_W'(roll % 2);
        if (roll < 82)
            return newest_stamp + win + 1 + TS_W'($urandom_range(0, 100));
        if (roll < 88)
            return newest_stamp;
        if (roll < 93)
            return newest_stamp - TS_W'($urandom_range(0, 3));
        if (roll < 97)
            return newest_stamp + TS_W'($urandom_range(0, cfg_gap));
        return {$urandom, $urandom};
    endfunction

    // Values lean on extremes and on the current range to hit ties
    function automatic logic signed [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return VAL_W'($urandom);
        if (roll < 60)
            return VAL_W'($urandom_range(0, 6) - 3);
        if (roll < 70)
            return low_val;
        if (roll < 80)
            return high_val;
        if (roll < 88)
            return VAL_MIN;
        if (roll < 96)
            return VAL_MAX;
        return '0;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int roll;
        roll = $urandom_range(99);
        if (fill != 0 && roll < 70)
            return IDX_W'($urandom_range(0, fill - 1));
        if (roll < 82)
            return fill[IDX_W-1:0];
        return IDX_W'($urandom);
    endfunction

    task automatic run_random_phase(input logic allow, input logic [CFG_W-1:0] window,
                                    input logic [CFG_W-1:0] min_gap, input int count,
                                    input int clear_pct, input int stride);
        int roll;
        int i;
        drain_results();
        write_reg(wsrmm_pkg::CFG_ENABLE, CFG_W'(allow));
        write_reg(wsrmm_pkg::CFG_WINDOW, window);
        write_reg(wsrmm_pkg::CFG_MIN_INTERVAL, min_gap);
        for (i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < clear_pct)
                send_word(wsrmm_pkg::OP_CLEAR, {$urandom, $urandom}, VAL_W'($urandom),
                          IDX_W'($urandom));
            else if (roll < clear_pct + 10)
                send_word(wsrmm_pkg::OP_RECOMPUTE, {$urandom, $urandom},
                          VAL_W'($urandom), IDX_W'($urandom));
            else if (roll < clear_pct + 25)
                send_word(wsrmm_pkg::OP_READ, {$urandom, $urandom}, VAL_W'($urandom),
                          pick_index());
            else
                send_word(wsrmm_pkg::OP_PUSH, pick_stamp(stride), pick_value(),
                          IDX_W'($urandom));
            // Now and then let all expected result words drain before going on
            if ($urandom_range(299) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // Reset defaults: empty store, pushes refused while disabled
    task automatic test_reset_defaults();
        send_word(wsrmm_pkg::OP_READ, '0, '0, '0);
        send_word(wsrmm_pkg::OP_RECOMPUTE, '0, '0, '0);
        send_word(wsrmm_pkg::OP_PUSH, 64'd5, 32'sd1, '0);
    endtask

    // Push acceptance: empty store, stale stamp, short gap, exact gap; reads
    task automatic test_push_rules();
        drain_results();
        write_reg(wsrmm_pkg::CFG_ENABLE, CFG_W'(1));
        write_reg(wsrmm_pkg::CFG_WINDOW, CFG_W'(100));
        write_reg(wsrmm_pkg::CFG_MIN_INTERVAL, CFG_W'(10));
        send_word(wsrmm_pkg::OP_PUSH, 64'd0, VAL_MIN, '0);
        send_word(wsrmm_pkg::OP_PUSH, 64'd0, 32'sd5, '0);
        send_word(wsrmm_pkg::OP_PUSH, 64'd9, 32'sd5, '0);
        send_word(wsrmm_pkg::OP_PUSH, 64'd10, VAL_MAX, '0);
        send_word(wsrmm_pkg::OP_READ, '0, '0, IDX_W'(0));
        send_word(wsrmm_pkg::OP_READ, '0, '0, IDX_W'(1));
        send_word(wsrmm_pkg::OP_READ, '0, '0, IDX_W'(2));
        send_word(wsrmm_pkg::OP_READ, '0, '0, '1);
    endtask

    // Evict the minimum, refresh, then evict the maximum
    task automatic test_eviction_marks();
        send_word(wsrmm_pkg::OP_PUSH, 64'd110, 32'sd0, '0);
        send_word(wsrmm_pkg::OP_RECOMPUTE, '0, '0, '0);
        send_word(wsrmm_pkg::OP_PUSH, 64'd120, -32'sd5, '0);
        send_word(wsrmm_pkg::OP_READ, '0, '0, IDX_W'(0));
    endtask

    // Clear, then push with a gap below the interval into the empty store
    task automatic test_clear_store();
        send_word(wsrmm_pkg::OP_CLEAR, '0, '0, '0);
        send_word(wsrmm_pkg::OP_READ, '0, '0, IDX_W'(0));
        send_word(wsrmm_pkg::OP_PUSH, 64'd3, 32'sd7, '0);
        send_word(wsrmm_pkg::OP_RECOMPUTE, '0, '0, '0);
    endtask

    // Largest timestamp with the widest window
    task automatic test_stamp_extremes();
        drain_results();
        write_reg(wsrmm_pkg::CFG_WINDOW, CFG_ALL_ONES);
        write_reg(wsrmm_pkg::CFG_MIN_INTERVAL, '0);
        send_word(wsrmm_pkg::OP_PUSH, TS_MAX, -32'sd1, '0);
        send_word(wsrmm_pkg::OP_PUSH, TS_MAX, 32'sd1, '0);
        send_word(wsrmm_pkg::OP_READ, '0, '0, IDX_W'(0));
        send_word(wsrmm_pkg::OP_CLEAR, '0, '0, '0);
    endtask

    // Fill the whole ring and overwrite the oldest entries
    task automatic test_store_wrap();
        int k;
        send_word(wsrmm_pkg::OP_CLEAR, '0, '0, '0);
        // Run the first half with no idling on either side
        idle_pct = 0;
        stall_pct = 0;
        for (k = 0; k < RING_DEPTH + 2; k++)
        begin
            if (k == RING_DEPTH / 2)
            begin
                idle_pct = 36;
                stall_pct = 36;
            end
            send_word(wsrmm_pkg::OP_PUSH, TS_W'(k + 1),
                      (k == 0) ? VAL_MIN : VAL_W'($urandom), IDX_W'($urandom));
        end
        send_word(wsrmm_pkg::OP_READ, '0, '0, IDX_W'(0));
        send_word(wsrmm_pkg::OP_READ, '0, '0, '1);
        send_word(wsrmm_pkg::OP_RECOMPUTE, '0, '0, '0);
        send_word(wsrmm_pkg::OP_CLEAR, '0, '0, '0);
    endtask

    task automatic test_random_traffic();
        run_random_phase(1'b1, CFG_W'(40), CFG_W'(0), 10, 4, 12);
        run_random_phase(1'b1, CFG_W'(1000), CFG_W'(5), 10, 3, 120);
        run_random_phase(1'b1, CFG_W'(0), CFG_W'(0), 6, 4, 3);
        run_random_phase(1'b0, CFG_W'(500), CFG_W'(0), 4, 4, 50);
        run_random_phase(1'b1, CFG_ALL_ONES, CFG_ALL_ONES, 6, 4, 1000);
        // Calm stretch with the widest window
        drain_results();
        idle_pct = 0;
        stall_pct = 0;
        run_random_phase(1'b1, CFG_ALL_ONES, CFG_W'(0), 14, 0, 40);
        idle_pct = 36;
        stall_pct = 36;
        run_random_phase(1'b1, CFG_W'(300), CFG_W'(3), 6, 4, 40);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_push_rules();
        test_eviction_marks();
        test_clear_store();
        test_stamp_extremes();
        test_store_wrap();
        test_random_traffic();
        drain_results();
        repeat (16) @(posedge clk);
        $display("covered %0d stored pushes, %0d refused, %0d reads in range,",
                 n_taken, n_refused, n_hits);
        $display("%0d recomputes, %0d clears, peak occupancy %0d of %0d, %0d words checked",
                 n_walks, n_wipes, peak_fill, RING_DEPTH, n_checked);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hung run
    initial
    begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
